[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tag store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SACTL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset
`define SACTL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

[hw/rtl/sactl_pkg.sv]
// ----------------------------------------------------------------------------
// sactl_pkg
// Fixed widths, opcodes and elaboration helpers for the LRU tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sactl_pkg;

   localparam int ADDR_W    = 32;
   localparam int OP_W      = 2;
   localparam int WAY_OUT_W = 2;
   localparam int AGE_W     = 8;

   localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

   localparam logic [OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // floor(log2(value)), evaluated at elaboration
   function automatic int floor_log2(input int unsigned value);
      int unsigned v;
      int          n;
      v = value;
      n = 0;
      for (int i = 0; i < 32; i++) begin
         if (v > 1) begin
            v = v >> 1;
            n = n + 1;
         end
      end
      return n;
   endfunction

endpackage

[hw/rtl/set_assoc_cache_tag_lru.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// Tag store of a set-associative cache with saturating age-based LRU.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, req_op, req_addr) takes one access:
//   read lookup, write lookup (marks the line dirty on a hit) or allocate.
//   Response channel (rsp_valid/rsp_ready) returns exactly one result per
//   request: hit, way, writeback and victim_addr.
//   Each request walks the ways of its set through one tag/age compare unit,
//   one way per cycle from the line RAM's single read port. A lookup hit
//   takes a scan pass plus an age update pass, a lookup miss the scan pass
//   only, an allocate the scan pass plus the allocating write, and an unused
//   opcode goes straight to the response. A new request is taken in the cycle
//   after the previous result moves into the response register, so the block
//   is through with one request before it takes the next. After reset the block
//   sweeps all 2**(set bits + way bits) lines of the line RAM to zero (256 at
//   the default sizes), one line per cycle, with req_ready low. A stalled
//   response holds in its register; the next request may still be taken and
//   waits finished until the response register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module set_assoc_cache_tag_lru #(
   parameter int LINE_BYTES = 32,
   parameter int NUM_SETS   = 64,
   parameter int WAYS       = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [sactl_pkg::OP_W-1:0]           req_op,
   input  logic [sactl_pkg::ADDR_W-1:0]         req_addr,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_hit,
   output logic [sactl_pkg::WAY_OUT_W-1:0]      rsp_way,
   output logic                                 rsp_writeback,
   output logic [sactl_pkg::ADDR_W-1:0]         rsp_victim_addr
);

   localparam int ADDR_W     = sactl_pkg::ADDR_W;
   localparam int AGE_W      = sactl_pkg::AGE_W;
   localparam int OFF_BITS   = sactl_pkg::floor_log2(LINE_BYTES);
   localparam int SET_BITS   = sactl_pkg::floor_log2(NUM_SETS);
   localparam int HIGH_SHIFT = OFF_BITS + SET_BITS;
   localparam int TAG_W      = ADDR_W - HIGH_SHIFT;
   localparam int SET_W      = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RAM_AW     = SET_W + WAY_W;
   localparam int RAM_DEPTH  = 1 << RAM_AW;
   localparam int LINE_W     = 2 + TAG_W + AGE_W;
   localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_ALLOC,
      ST_FINISH
   } state_type;

   state_type state_ff;

   logic [RAM_AW-1:0]  clr_cnt_ff;
   logic [WAY_W-1:0]   way_cnt_ff;
   logic [1:0]         op_ff;
   logic [SET_W-1:0]   set_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic               found_ff;
   logic [WAY_W-1:0]   found_way_ff;
   logic [WAY_W-1:0]   old_way_ff;
   logic [AGE_W-1:0]   old_age_ff;
   logic               old_dirty_ff;
   logic [TAG_W-1:0]   old_tag_ff;

   logic                                 pend_hit_ff;
   logic [sactl_pkg::WAY_OUT_W-1:0]      pend_way_ff;
   logic                                 pend_wb_ff;
   logic [ADDR_W-1:0]                    pend_victim_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_hit_ff;
   logic [sactl_pkg::WAY_OUT_W-1:0]      rsp_way_ff;
   logic                                 rsp_wb_ff;
   logic [ADDR_W-1:0]                    rsp_victim_ff;

   // address split
   logic [ADDR_W-1:0] set_full;
   logic [ADDR_W-1:0] tag_full;
   logic [SET_W-1:0]  req_set;
   logic [TAG_W-1:0]  req_tag;

   assign set_full = (req_addr >> OFF_BITS) & ((ADDR_W'(1) << SET_BITS) - ADDR_W'(1));
   assign tag_full = req_addr >> HIGH_SHIFT;
   assign req_set  = set_full[SET_W-1:0];
   assign req_tag  = tag_full[TAG_W-1:0];

   // line RAM
   logic              ram_wr_en;
   logic [RAM_AW-1:0] ram_wr_addr;
   logic [LINE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [RAM_AW-1:0] ram_rd_addr;
   logic [LINE_W-1:0] ram_rd_data;

   sactl_ram #(
      .WIDTH (LINE_W),
      .DEPTH (RAM_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic             d_valid;
   logic             d_dirty;
   logic [TAG_W-1:0] d_tag;
   logic [AGE_W-1:0] d_age;

   assign d_valid = ram_rd_data[LINE_W-1];
   assign d_dirty = ram_rd_data[LINE_W-2];
   assign d_tag   = ram_rd_data[AGE_W +: TAG_W];
   assign d_age   = ram_rd_data[AGE_W-1:0];

   // shared compare unit, one way per cycle
   logic             is_lookup;
   logic             tag_hit;
   logic             found_in;
   logic             older;
   logic             is_hit_way;
   logic             new_dirty;
   logic [AGE_W-1:0] new_age;
   logic [WAY_W-1:0] alloc_way;
   logic             alloc_wb;
   logic [ADDR_W-1:0] victim_calc;
   logic [WAY_W-1:0] next_way;
   logic             req_xfer;

   assign is_lookup  = (op_ff == sactl_pkg::OP_READ) || (op_ff == sactl_pkg::OP_WRITE);
   assign tag_hit    = !found_ff && d_valid && (d_tag == tag_ff);
   assign found_in   = found_ff || tag_hit;
   assign older      = (way_cnt_ff == '0) || (d_age > old_age_ff);
   assign is_hit_way = (way_cnt_ff == found_way_ff);
   assign new_dirty  = d_dirty || (is_hit_way && (op_ff == sactl_pkg::OP_WRITE));
   assign new_age    = is_hit_way ? '0 :
                       (d_valid && (d_age != sactl_pkg::AGE_MAX)) ? d_age + 1'b1 : d_age;
   assign alloc_way  = found_ff ? found_way_ff : old_way_ff;
   assign alloc_wb   = !found_ff && old_dirty_ff;
   assign victim_calc = (ADDR_W'(old_tag_ff) << HIGH_SHIFT) | (ADDR_W'(set_ff) << OFF_BITS);
   assign next_way   = WAY_W'(way_cnt_ff + 1'b1);
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = {set_ff, way_cnt_ff};
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {set_ff, next_way};
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
         end
         ST_IDLE: begin
            if (req_valid && (req_op != sactl_pkg::OP_UNUSED)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = {req_set, WAY_W'(0)};
            end
         end
         ST_SCAN: begin
            if (way_cnt_ff != LAST_WAY) begin
               ram_rd_en = 1'b1;
            end else if (is_lookup && found_in) begin
               // start the update pass at way 0
               ram_rd_en   = 1'b1;
               ram_rd_addr = {set_ff, WAY_W'(0)};
            end
         end
         ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {d_valid, new_dirty, d_tag, new_age};
            ram_rd_en   = (way_cnt_ff != LAST_WAY);
         end
         ST_ALLOC: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = {set_ff, alloc_way};
            ram_wr_data = {1'b1, 1'b0, tag_ff, AGE_W'(0)};
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         way_cnt_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // finish reloads the response register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == RAM_AW'(RAM_DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_xfer) begin
                  op_ff          <= req_op;
                  set_ff         <= req_set;
                  tag_ff         <= req_tag;
                  found_ff       <= 1'b0;
                  way_cnt_ff     <= '0;
                  pend_hit_ff    <= 1'b0;
                  pend_way_ff    <= '0;
                  pend_wb_ff     <= 1'b0;
                  pend_victim_ff <= '0;
                  state_ff       <= (req_op == sactl_pkg::OP_UNUSED) ? ST_FINISH : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (is_lookup) begin
                  if (tag_hit) begin
                     found_ff     <= 1'b1;
                     found_way_ff <= way_cnt_ff;
                  end
               end else begin
                  if (!found_ff && !d_valid) begin
                     found_ff     <= 1'b1;
                     found_way_ff <= way_cnt_ff;
                  end
                  if (older) begin
                     old_way_ff   <= way_cnt_ff;
                     old_age_ff   <= d_age;
                     old_dirty_ff <= d_dirty;
                     old_tag_ff   <= d_tag;
                  end
               end
               if (way_cnt_ff == LAST_WAY) begin
                  way_cnt_ff <= '0;
                  if (!is_lookup) begin
                     state_ff <= ST_ALLOC;
                  end else if (found_in) begin
                     state_ff <= ST_UPDATE;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end else begin
                  way_cnt_ff <= next_way;
               end
            end
            ST_UPDATE: begin
               if (way_cnt_ff == LAST_WAY) begin
                  way_cnt_ff  <= '0;
                  pend_hit_ff <= 1'b1;
                  pend_way_ff <= sactl_pkg::WAY_OUT_W'(found_way_ff);
                  state_ff    <= ST_FINISH;
               end else begin
                  way_cnt_ff <= next_way;
               end
            end
            ST_ALLOC: begin
               pend_way_ff    <= sactl_pkg::WAY_OUT_W'(alloc_way);
               pend_wb_ff     <= alloc_wb;
               pend_victim_ff <= alloc_wb ? victim_calc : '0;
               state_ff       <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_hit_ff    <= pend_hit_ff;
                  rsp_way_ff    <= pend_way_ff;
                  rsp_wb_ff     <= pend_wb_ff;
                  rsp_victim_ff <= pend_victim_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_way         = rsp_way_ff;
   assign rsp_writeback   = rsp_wb_ff;
   assign rsp_victim_addr = rsp_victim_ff;

   // read and write never target the same line in one cycle
   `SACTL_ASSERT_IMP(a_no_rw_collision, clock, reset, ram_wr_en && ram_rd_en,
      ram_wr_addr != ram_rd_addr)
   // a clean or absent victim reports a zero address; a writeback never comes with a hit
   `SACTL_ASSERT_IMP(a_victim_zero, clock, reset, rsp_valid_ff && !rsp_wb_ff,
      rsp_victim_ff == '0)
   `SACTL_ASSERT_IMP(a_wb_no_hit, clock, reset, rsp_valid_ff && rsp_wb_ff, !rsp_hit_ff)
   // an accepted request always leaves idle
   `SACTL_ASSERT_NXT(a_busy_after_xfer, clock, reset, req_xfer, state_ff != ST_IDLE)

endmodule

[hw/rtl/sactl_ram.sv]
// ----------------------------------------------------------------------------
// sactl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sactl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[test/set_assoc_cache_tag_lru_checker.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru_checker
// Watches the access and response channels of the LRU tag store. It keeps its
// own copy of valid, dirty, tag and age per line, works out the response of
// every accepted access and compares each returned response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_tag_lru_checker #(
   parameter int LINE_BYTES = 32,
   parameter int NUM_SETS   = 64,
   parameter int WAYS       = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [sactl_pkg::OP_W-1:0]      req_op,
   input  logic [sactl_pkg::ADDR_W-1:0]    req_addr,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_hit,
   input  logic [sactl_pkg::WAY_OUT_W-1:0] rsp_way,
   input  logic                            rsp_writeback,
   input  logic [sactl_pkg::ADDR_W-1:0]    rsp_victim_addr,
   output int                              mismatch_count,
   output int                              pending_count
);

   localparam int ADDR_W    = sactl_pkg::ADDR_W;
   localparam int OP_W      = sactl_pkg::OP_W;
   localparam int WAY_OUT_W = sactl_pkg::WAY_OUT_W;
   localparam int AGE_W     = sactl_pkg::AGE_W;

   // floor(log2) of each size
   localparam int OFF_W     = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_W     = $clog2(NUM_SETS + 1) - 1;
   localparam int NUM_LINES = NUM_SETS * WAYS;

   typedef struct packed {
      logic                 hit;
      logic [WAY_OUT_W-1:0] way;
      logic                 writeback;
      logic [ADDR_W-1:0]    victim_addr;
   } access_result_type;

   logic              entry_valid [NUM_LINES];
   logic              entry_dirty [NUM_LINES];
   logic [ADDR_W-1:0] entry_tag   [NUM_LINES];
   logic [AGE_W-1:0]  entry_age   [NUM_LINES];

   access_result_type expected_q [$];
   int                bad_count = 0;
   int                outstanding = 0;

   assign mismatch_count = bad_count;
   assign pending_count  = outstanding;

   function automatic access_result_type predict_access(input logic [OP_W-1:0]   op,
                                                        input logic [ADDR_W-1:0] addr);
      access_result_type res;
      int unsigned       set_idx;
      int unsigned       base;
      int unsigned       way_sel;
      logic [ADDR_W-1:0] tag;
      int                best_age;
      bit                found;
      res     = '0;
      set_idx = (addr >> OFF_W) & ((1 << SET_W) - 1);
      tag     = addr >> (OFF_W + SET_W);
      base    = set_idx * WAYS;
      case (op) inside
         sactl_pkg::OP_READ, sactl_pkg::OP_WRITE: begin
            // first matching way wins, even when a duplicate line exists
            for (int w = 0; w < WAYS; w++) begin
               if (!res.hit && entry_valid[base+w] && entry_tag[base+w] == tag) begin
                  res.hit = 1'b1;
                  res.way = WAY_OUT_W'(w);
                  for (int v = 0; v < WAYS; v++) begin
                     if (v != w && entry_valid[base+v] &&
                         entry_age[base+v] != sactl_pkg::AGE_MAX)
                        entry_age[base+v] = entry_age[base+v] + 1'b1;
                  end
                  entry_age[base+w] = '0;
                  if (op == sactl_pkg::OP_WRITE)
                     entry_dirty[base+w] = 1'b1;
               end
            end
         end
         sactl_pkg::OP_ALLOC: begin
            found    = 1'b0;
            best_age = -1;
            way_sel  = 0;
            // first invalid way, else oldest with the lowest way on a tie
            for (int w = 0; w < WAYS; w++) begin
               if (!found) begin
                  if (!entry_valid[base+w]) begin
                     way_sel = w;
                     found   = 1'b1;
                  end else if (int'(entry_age[base+w]) > best_age) begin
                     best_age = int'(entry_age[base+w]);
                     way_sel  = w;
                  end
               end
            end
            if (!found && entry_dirty[base+way_sel]) begin
               res.writeback   = 1'b1;
               res.victim_addr = (entry_tag[base+way_sel] << (OFF_W + SET_W)) |
                                 (set_idx << OFF_W);
            end
            res.way                  = WAY_OUT_W'(way_sel);
            entry_valid[base+way_sel] = 1'b1;
            entry_dirty[base+way_sel] = 1'b0;
            entry_tag[base+way_sel]   = tag;
            entry_age[base+way_sel]   = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
                                input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         bad_count++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      access_result_type exp_res;
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            entry_valid[i] = 1'b0;
            entry_dirty[i] = 1'b0;
            entry_tag[i]   = '0;
            entry_age[i]   = '0;
         end
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               bad_count++;
               $display("%0t: response with no access outstanding (hit %0d way %0d)",
                        $time, rsp_hit, rsp_way);
            end else begin
               exp_res = expected_q.pop_front();
               compare_field("hit", ADDR_W'(exp_res.hit), ADDR_W'(rsp_hit));
               compare_field("way", ADDR_W'(exp_res.way), ADDR_W'(rsp_way));
               compare_field("writeback", ADDR_W'(exp_res.writeback),
                             ADDR_W'(rsp_writeback));
               compare_field("victim_addr", exp_res.victim_addr, rsp_victim_addr);
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_access(req_op, req_addr));
      end
      outstanding = expected_q.size();
   end

endmodule

[test/tb_set_assoc_cache_tag_lru.sv]
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_lru
// Drives lookups, allocates and unused opcodes into the LRU tag store with
// random idle gaps and response stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lru;

   localparam int ADDR_W     = sactl_pkg::ADDR_W;
   localparam int OP_W       = sactl_pkg::OP_W;
   localparam int WAY_OUT_W  = sactl_pkg::WAY_OUT_W;

   localparam int LINE_BYTES = 32;
   localparam int NUM_SETS   = 64;
   localparam int WAYS       = 4;
   localparam int OFF_W      = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_W      = $clog2(NUM_SETS + 1) - 1;
   localparam int TAG_W      = ADDR_W - OFF_W - SET_W;

   localparam int ACCESS_TARGET = 1650;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 24;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op = sactl_pkg::OP_READ;
   logic [ADDR_W-1:0]    req_addr = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b1;
   logic                 rsp_hit;
   logic [WAY_OUT_W-1:0] rsp_way;
   logic                 rsp_writeback;
   logic [ADDR_W-1:0]    rsp_victim_addr;

   int mismatch_count;
   int pending_count;
   int accesses_sent = 0;
   int quiet_cycles = 0;
   int sink_hold = 0;
   bit idling_on = 1'b1;

   logic [TAG_W-1:0] hot_tag [3][8];
   int unsigned      hot_set [3];

   always #1 clock = ~clock;

   set_assoc_cache_tag_lru #(
      .LINE_BYTES(LINE_BYTES),
      .NUM_SETS  (NUM_SETS),
      .WAYS      (WAYS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_addr       (req_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_way        (rsp_way),
      .rsp_writeback  (rsp_writeback),
      .rsp_victim_addr(rsp_victim_addr)
   );

   set_assoc_cache_tag_lru_checker #(
      .LINE_BYTES(LINE_BYTES),
      .NUM_SETS  (NUM_SETS),
      .WAYS      (WAYS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_addr       (req_addr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hit        (rsp_hit),
      .rsp_way        (rsp_way),
      .rsp_writeback  (rsp_writeback),
      .rsp_victim_addr(rsp_victim_addr),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // response back-pressure: mostly short stalls, some long, some stall-free runs
   always @(negedge clock) begin : sink_pace
      int r;
      if (sink_hold == 0) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_ready = 1'b1;
            sink_hold = $urandom_range(1, 20);
         end else if (r < 65) begin
            rsp_ready = 1'b1;
            sink_hold = $urandom_range(50, 200);
         end else if (r < 95) begin
            rsp_ready = 1'b0;
            sink_hold = $urandom_range(1, 4);
         end else begin
            rsp_ready = 1'b0;
            sink_hold = $urandom_range(20, 60);
         end
      end else begin
         sink_hold = sink_hold - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                   input int unsigned set_idx,
                                                   input int unsigned offset);
      return {tag, set_idx[SET_W-1:0], offset[OFF_W-1:0]};
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idling_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_access(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op    = op;
      req_addr  = addr;
      do @(posedge clock); while (!req_ready);
      accesses_sent++;
      @(negedge clock);
   endtask

   task automatic drain_responses();
      req_valid = 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   task automatic refresh_hot(input int h);
      hot_set[h] = $urandom_range(0, NUM_SETS - 1);
      for (int k = 0; k < 8; k++)
         hot_tag[h][k] = TAG_W'($urandom_range(0, 2**TAG_W - 1));
   endtask

   // drive one set's ages into saturation, then evict on a three-way tie
   task automatic saturate_ages();
      int unsigned      set_idx;
      logic [TAG_W-1:0] tags [5];
      set_idx = $urandom_range(1, NUM_SETS - 2);
      for (int i = 0; i < 5; i++)
         tags[i] = TAG_W'($urandom_range(0, 2**TAG_W - 1));
      for (int i = 0; i < WAYS; i++)
         send_access(sactl_pkg::OP_ALLOC,
                     line_addr(tags[i], set_idx, $urandom_range(0, LINE_BYTES - 1)));
      send_access(sactl_pkg::OP_WRITE,
                  line_addr(tags[1], set_idx, $urandom_range(0, LINE_BYTES - 1)));
      for (int i = 0; i < 270; i++)
         send_access(sactl_pkg::OP_READ,
                     line_addr(tags[0], set_idx, $urandom_range(0, LINE_BYTES - 1)));
      send_access(sactl_pkg::OP_ALLOC, line_addr(tags[4], set_idx, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(tags[1], set_idx, 0));
   endtask

   task automatic run_episode();
      int               h;
      int               pool_n;
      int               len;
      int               r;
      logic [OP_W-1:0]  op;
      logic [ADDR_W-1:0] addr;
      h = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0)
         refresh_hot(h);
      pool_n = $urandom_range(2, 8);
      len    = $urandom_range(10, 40);
      for (int i = 0; i < len; i++) begin
         r    = $urandom_range(0, 99);
         addr = line_addr(hot_tag[h][$urandom_range(0, pool_n - 1)], hot_set[h],
                          $urandom_range(0, LINE_BYTES - 1));
         if (r < 30) begin
            op = sactl_pkg::OP_ALLOC;
         end else if (r < 60) begin
            op = sactl_pkg::OP_READ;
         end else if (r < 90) begin
            op = sactl_pkg::OP_WRITE;
         end else if (r < 93) begin
            op = sactl_pkg::OP_UNUSED;
         end else begin
            // noise: any opcode, any address
            op   = OP_W'($urandom_range(0, 3));
            addr = $urandom();
         end
         send_access(op, addr);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // set 0: miss, duplicate allocate, hits, dirty line, evictions
      send_access(sactl_pkg::OP_READ,  line_addr(0, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(0, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(0, 0, 0));
      send_access(sactl_pkg::OP_READ,  line_addr(0, 0, LINE_BYTES - 1));
      send_access(sactl_pkg::OP_WRITE, line_addr(0, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(1, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr({TAG_W{1'b1}}, 0, 0));
      send_access(sactl_pkg::OP_WRITE, line_addr({TAG_W{1'b1}}, 0, 7));
      send_access(sactl_pkg::OP_READ,  line_addr(1, 0, 0));
      send_access(sactl_pkg::OP_WRITE, line_addr(9, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(2, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(3, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(4, 0, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(5, 0, 0));
      send_access(sactl_pkg::OP_UNUSED, {ADDR_W{1'b1}});
      send_access(sactl_pkg::OP_UNUSED, '0);
      // top set: all-ones line made dirty, then pushed out
      send_access(sactl_pkg::OP_ALLOC, {ADDR_W{1'b1}});
      send_access(sactl_pkg::OP_WRITE, {ADDR_W{1'b1}});
      send_access(sactl_pkg::OP_ALLOC, line_addr(0, NUM_SETS - 1, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(1, NUM_SETS - 1, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(2, NUM_SETS - 1, 0));
      send_access(sactl_pkg::OP_READ,  line_addr(0, NUM_SETS - 1, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(3, NUM_SETS - 1, 0));
      send_access(sactl_pkg::OP_ALLOC, line_addr(4, NUM_SETS - 1, 0));
      drain_responses();

      for (int h = 0; h < 3; h++)
         refresh_hot(h);
      saturate_ages();
      while (accesses_sent < ACCESS_TARGET) begin
         idling_on = ($urandom_range(0, 4) != 0);
         run_episode();
         if ($urandom_range(0, 9) == 0)
            drain_responses();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
